// ===== design/lfps_pkg.sv =====
// Package for the line-follow PD steering block: widths, configuration
// register indexes, sensor weights and the control struct of the shared MAC.
// No dependencies.
package lfps_pkg;

    // Sensor front end
    localparam int SENSOR_COUNT = 5;
    localparam int SAMPLE_W     = 12;
    localparam int ADC_BITS     = 12;
    localparam int FULL_SCALE   = (1 << ADC_BITS) - 1;
    localparam int SCALE_RANGE  = 1000;
    localparam int THR_W        = 10;
    localparam int SCALE_W      = THR_W + ((ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W);
    localparam int WEIGHT_W     = 5;
    localparam int COUNT_W      = 3;

    // Error and PID datapath
    localparam int ERR_W        = 13;
    localparam int DIFF_W       = ERR_W + 1;
    localparam int ESUM_W       = 15;
    localparam int CORR_W       = 16;
    localparam int DUTY_W       = 15;
    localparam int PCT_W        = 7;
    localparam int ILIM_W       = 6;
    localparam int FRAC_W       = 8;
    localparam int ERR_LOST     = 2048;

    // Serial divider
    localparam int DIV_W        = 12;
    localparam int DIV_CNT_W    = 4;
    localparam int DIVISOR_W    = COUNT_W;
    localparam int REM_W        = DIVISOR_W + 1;

    // Shared multiply-accumulate unit
    localparam int GAIN_W       = 16;
    localparam int MAC_B_W      = ESUM_W;
    localparam int PROD_W       = GAIN_W + 1 + MAC_B_W;
    localparam int ACC_W        = PROD_W + 2;

    // Stream and configuration ports
    localparam int IN_TDATA_W   = 64;
    localparam int OUT_TDATA_W  = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd7;

    localparam logic [1:0] MODE_FOLLOW     = 2'd0;
    localparam logic [1:0] MODE_TURN_LEFT  = 2'd1;
    localparam logic [1:0] MODE_TURN_RIGHT = 2'd2;

    typedef struct packed {
        logic clr;   // zero the accumulator
        logic vld;   // operands carry a term this cycle
    } t_mac_ctl;

    // Position weight of each sensor, far left first
    function automatic logic signed [WEIGHT_W-1:0] sensor_weight(
        input logic [COUNT_W-1:0] idx);
        logic signed [WEIGHT_W-1:0] w;
        case (idx)
            3'd0:    w = -5'sd5;
            3'd1:    w = -5'sd3;
            3'd2:    w = 5'sd1;
            3'd3:    w = 5'sd3;
            3'd4:    w = 5'sd5;
            default: w = 5'sd0;
        endcase
        return w;
    endfunction

endpackage

// ===== design/lfps_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on lfps_pkg for its widths.
module lfps_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [lfps_pkg::DIV_W-1:0]         i_dividend,
    input  logic [lfps_pkg::DIVISOR_W-1:0]     i_divisor,
    output logic                               o_done,
    output logic [lfps_pkg::DIV_W-1:0]         o_quot
);

    logic                             r_busy;
    logic                             r_done;
    logic [lfps_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [lfps_pkg::DIV_W-1:0]       r_work;
    logic [lfps_pkg::REM_W-1:0]       r_rem;
    logic [lfps_pkg::DIVISOR_W-1:0]   r_dvsr;

    logic [lfps_pkg::REM_W-1:0]       w_shift;
    logic                             w_ge;
    logic [lfps_pkg::REM_W-1:0]       n_rem;

    always_comb begin
        w_shift = {r_rem[lfps_pkg::REM_W-2:0], r_work[lfps_pkg::DIV_W-1]};
        w_ge    = (w_shift >= {1'b0, r_dvsr});
        n_rem   = w_ge ? (w_shift - {1'b0, r_dvsr}) : w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= lfps_pkg::DIV_CNT_W'(lfps_pkg::DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[lfps_pkg::DIV_W-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

// ===== design/lfps_mac.sv =====
// Shared multiply-accumulate unit for the PID terms: registered product,
// then accumulate. Depends on lfps_pkg for widths and the control struct.
module lfps_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  lfps_pkg::t_mac_ctl                      i_ctl,
    input  logic [lfps_pkg::GAIN_W-1:0]             i_gain,
    input  logic signed [lfps_pkg::MAC_B_W-1:0]     i_opnd,
    output logic signed [lfps_pkg::ACC_W-1:0]       o_acc
);

    logic signed [lfps_pkg::PROD_W-1:0] w_prod;
    logic signed [lfps_pkg::PROD_W-1:0] r_prod;
    logic                               r_pvld;
    logic signed [lfps_pkg::ACC_W-1:0]  r_acc;

    assign w_prod = $signed({1'b0, i_gain}) * i_opnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
            r_acc  <= '0;
        end else if (i_ctl.clr) begin
            r_pvld <= 1'b0;
            r_acc  <= '0;
        end else begin
            r_pvld <= i_ctl.vld;
            if (r_pvld) begin
                r_acc <= r_acc + {{(lfps_pkg::ACC_W - lfps_pkg::PROD_W){r_prod[lfps_pkg::PROD_W-1]}},
                                  r_prod};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prod <= w_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== design/line_follow_pd_steering.sv =====
// Line-follow steering controller: one transaction of five sensor samples in,
// one transaction of turn mode, motor directions, duties, error and PID
// correction out. A transaction with at least one sensor on the line goes
// through the sensor scan, the serial divider that forms the position error,
// the shared multiply-accumulate unit for the three PID terms, and the
// sequencing states; with no sensor on the line the divider is skipped. The
// input side is ready only while the sequencer is idle; a finished result
// waits in the output register and does not hold off the next input, but the
// next result waits in the duty state until the last one is taken.
// Configuration writes go through i_cfg_we, i_cfg_idx and i_cfg_data.
// Depends on lfps_pkg, lfps_div and lfps_mac.
module line_follow_pd_steering (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample_far_left, sample_near_left, sample_center, sample_near_right,
    // sample_far_right (12 bits each), zero pad
    input  logic [lfps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // turn_mode (2), left_forward (1), right_forward (1), left_duty (15),
    // right_duty (15), line_error (13), steer_correction (16), zero pad
    output logic [lfps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_PICK = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_PREP = 7'b0010000,
        ST_MAC  = 7'b0100000,
        ST_CORR = 7'b1000000
    } t_state_base;

    // The states of t_state_base with an extra duty state
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SCAN = 8'b00000010,
        S_PICK = 8'b00000100,
        S_DIV  = 8'b00001000,
        S_PREP = 8'b00010000,
        S_MAC  = 8'b00100000,
        S_CORR = 8'b01000000,
        S_DUTY = 8'b10000000
    } t_state;

    localparam int SW = lfps_pkg::SAMPLE_W;
    localparam int NS = lfps_pkg::SENSOR_COUNT;
    localparam int XW = lfps_pkg::DUTY_W + 3;   // duty sum before clamping

    // Configuration registers
    logic [lfps_pkg::PCT_W-1:0]   r_base;
    logic [lfps_pkg::PCT_W-1:0]   r_min;
    logic [lfps_pkg::PCT_W-1:0]   r_max;
    logic [lfps_pkg::THR_W-1:0]   r_thr;
    logic [lfps_pkg::GAIN_W-1:0]  r_gp;
    logic [lfps_pkg::GAIN_W-1:0]  r_gi;
    logic [lfps_pkg::GAIN_W-1:0]  r_gd;
    logic [lfps_pkg::ILIM_W-1:0]  r_ilim;

    // Sequencer and working registers
    t_state                                    r_state;
    t_state                                    n_state;
    logic [lfps_pkg::COUNT_W-1:0]              r_cnt;
    logic [SW-1:0]                             r_samp [NS];
    logic [NS-1:0]                             r_hits;
    logic [lfps_pkg::COUNT_W-1:0]              r_n;
    logic signed [lfps_pkg::WEIGHT_W-1:0]      r_w;
    logic                                      r_neg;
    logic signed [lfps_pkg::ERR_W-1:0]         r_err;
    logic signed [lfps_pkg::ERR_W-1:0]         r_last_err;
    logic signed [lfps_pkg::ESUM_W-1:0]        r_esum;
    logic signed [lfps_pkg::DIFF_W-1:0]        r_diff;
    logic signed [lfps_pkg::CORR_W-1:0]        r_corr;

    // Output register
    logic                                      r_ovld;
    logic [1:0]                                r_mode;
    logic                                      r_lf;
    logic                                      r_rf;
    logic [lfps_pkg::DUTY_W-1:0]               r_lduty;
    logic [lfps_pkg::DUTY_W-1:0]               r_rduty;
    logic signed [lfps_pkg::ERR_W-1:0]         r_oerr;
    logic signed [lfps_pkg::CORR_W-1:0]        r_ocorr;

    logic                                      w_in_acc;
    logic                                      w_out_acc;
    logic                                      w_out_free;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 7'd55;
            r_min  <= 7'd44;
            r_max  <= 7'd64;
            r_thr  <= 10'd950;
            r_gp   <= 16'd230;
            r_gi   <= 16'd0;
            r_gd   <= 16'd1664;
            r_ilim <= 6'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lfps_pkg::CFG_BASE_DUTY:      r_base <= i_cfg_data[lfps_pkg::PCT_W-1:0];
                lfps_pkg::CFG_MIN_DUTY:       r_min  <= i_cfg_data[lfps_pkg::PCT_W-1:0];
                lfps_pkg::CFG_MAX_DUTY:       r_max  <= i_cfg_data[lfps_pkg::PCT_W-1:0];
                lfps_pkg::CFG_HIT_THRESHOLD:  r_thr  <= i_cfg_data[lfps_pkg::THR_W-1:0];
                lfps_pkg::CFG_GAIN_P:         r_gp   <= i_cfg_data[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::CFG_GAIN_I:         r_gi   <= i_cfg_data[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::CFG_GAIN_D:         r_gd   <= i_cfg_data[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::CFG_INTEGRAL_LIMIT: r_ilim <= i_cfg_data[lfps_pkg::ILIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sensor scan: one sample a cycle.
    // floor(s*1000/full) < 1000-thr is the same test as s*1000 < (1000-thr)*full
    // ------------------------------------------------------------------
    logic [SW-1:0]                    w_s;
    logic [lfps_pkg::THR_W-1:0]       w_thr_k;
    logic [lfps_pkg::SCALE_W-1:0]     w_s_scaled;
    logic [lfps_pkg::SCALE_W-1:0]     w_limit;
    logic                             w_hit;

    always_comb begin
        if (32'(r_samp[0]) > 32'(lfps_pkg::FULL_SCALE)) begin
            w_s = SW'(lfps_pkg::FULL_SCALE);
        end else begin
            w_s = r_samp[0];
        end
        if (r_thr < lfps_pkg::THR_W'(lfps_pkg::SCALE_RANGE)) begin
            w_thr_k = lfps_pkg::THR_W'(lfps_pkg::SCALE_RANGE) - r_thr;
        end else begin
            w_thr_k = '0;
        end
        w_s_scaled = lfps_pkg::SCALE_W'(w_s) * lfps_pkg::SCALE_W'(lfps_pkg::SCALE_RANGE);
        w_limit    = lfps_pkg::SCALE_W'(w_thr_k) * lfps_pkg::SCALE_W'(lfps_pkg::FULL_SCALE);
        w_hit      = (w_s_scaled < w_limit);
    end

    // ------------------------------------------------------------------
    // Error numerator (w-1)*256 as sign and magnitude for the divider
    // ------------------------------------------------------------------
    logic signed [lfps_pkg::WEIGHT_W-1:0] w_wm1;
    logic [lfps_pkg::WEIGHT_W-1:0]        w_wmag;
    logic [lfps_pkg::DIV_W-1:0]           w_dividend;
    logic                                 w_div_start;
    logic                                 w_div_done;
    logic [lfps_pkg::DIV_W-1:0]           w_div_quot;

    always_comb begin
        w_wm1      = r_w - 5'sd1;
        w_wmag     = w_wm1[lfps_pkg::WEIGHT_W-1] ? (-w_wm1) : w_wm1;
        w_dividend = {w_wmag[lfps_pkg::DIV_W-lfps_pkg::FRAC_W-1:0], {lfps_pkg::FRAC_W{1'b0}}};
        w_div_start = (r_state == S_PICK) && (r_n != '0);
    end

    lfps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // ------------------------------------------------------------------
    // PID preparation: derivative and clamped integral
    // ------------------------------------------------------------------
    logic signed [lfps_pkg::ESUM_W:0]     w_sum;
    logic signed [lfps_pkg::ESUM_W:0]     w_lim;
    logic signed [lfps_pkg::ESUM_W:0]     w_esum_c;
    logic signed [lfps_pkg::DIFF_W-1:0]   w_diff;

    always_comb begin
        w_sum = {r_esum[lfps_pkg::ESUM_W-1], r_esum}
              + {{(lfps_pkg::ESUM_W + 1 - lfps_pkg::ERR_W){r_err[lfps_pkg::ERR_W-1]}}, r_err};
        w_lim = $signed({2'b00, r_ilim, {lfps_pkg::FRAC_W{1'b0}}});
        if (w_sum > w_lim) begin
            w_esum_c = w_lim;
        end else if (w_sum < -w_lim) begin
            w_esum_c = -w_lim;
        end else begin
            w_esum_c = w_sum;
        end
        w_diff = {r_err[lfps_pkg::ERR_W-1], r_err} - {r_last_err[lfps_pkg::ERR_W-1], r_last_err};
    end

    // ------------------------------------------------------------------
    // Shared MAC: gain_p*err, gain_i*sum, gain_d*diff, one term a cycle
    // ------------------------------------------------------------------
    lfps_pkg::t_mac_ctl                        w_mac_ctl;
    logic [lfps_pkg::GAIN_W-1:0]               w_mac_gain;
    logic signed [lfps_pkg::MAC_B_W-1:0]       w_mac_opnd;
    logic signed [lfps_pkg::ACC_W-1:0]         w_acc;

    always_comb begin
        w_mac_ctl.clr = (r_state == S_PREP);
        w_mac_ctl.vld = (r_state == S_MAC) && (r_cnt < 3'd3);
        case (r_cnt)
            3'd0: begin
                w_mac_gain = r_gp;
                w_mac_opnd = {{(lfps_pkg::MAC_B_W - lfps_pkg::ERR_W){r_err[lfps_pkg::ERR_W-1]}},
                              r_err};
            end
            3'd1: begin
                w_mac_gain = r_gi;
                w_mac_opnd = r_esum;
            end
            3'd2: begin
                w_mac_gain = r_gd;
                w_mac_opnd = {{(lfps_pkg::MAC_B_W - lfps_pkg::DIFF_W){r_diff[lfps_pkg::DIFF_W-1]}},
                              r_diff};
            end
            default: begin
                w_mac_gain = '0;
                w_mac_opnd = '0;
            end
        endcase
    end

    lfps_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_gain  (w_mac_gain),
        .i_opnd  (w_mac_opnd),
        .o_acc   (w_acc)
    );

    // Divide by 256 truncating toward zero, then saturate to 16 bits
    logic signed [lfps_pkg::ACC_W-1:0]   w_acc_adj;
    logic signed [lfps_pkg::ACC_W-1:0]   w_q;
    logic signed [lfps_pkg::CORR_W-1:0]  w_corr;

    always_comb begin
        w_acc_adj = w_acc + (w_acc[lfps_pkg::ACC_W-1] ? lfps_pkg::ACC_W'(255) : '0);
        w_q       = w_acc_adj >>> lfps_pkg::FRAC_W;
        if (!w_q[lfps_pkg::ACC_W-1] && (|w_q[lfps_pkg::ACC_W-2:lfps_pkg::CORR_W-1])) begin
            w_corr = {1'b0, {(lfps_pkg::CORR_W-1){1'b1}}};
        end else if (w_q[lfps_pkg::ACC_W-1] && !(&w_q[lfps_pkg::ACC_W-2:lfps_pkg::CORR_W-1])) begin
            w_corr = {1'b1, {(lfps_pkg::CORR_W-1){1'b0}}};
        end else begin
            w_corr = w_q[lfps_pkg::CORR_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Duties and turn decision
    // ------------------------------------------------------------------
    function automatic logic [lfps_pkg::DUTY_W-1:0] clamp_duty(
        input logic signed [XW-1:0]       x,
        input logic [lfps_pkg::PCT_W-1:0] lo_pct,
        input logic [lfps_pkg::PCT_W-1:0] hi_pct);
        logic signed [XW-1:0] lo;
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] y;
        lo = $signed({3'b000, lo_pct, {lfps_pkg::FRAC_W{1'b0}}});
        hi = $signed({3'b000, hi_pct, {lfps_pkg::FRAC_W{1'b0}}});
        y  = x;
        if (y < lo) y = lo;
        if (y > hi) y = hi;
        return y[lfps_pkg::DUTY_W-1:0];
    endfunction

    logic signed [XW-1:0]          w_base;
    logic signed [XW-1:0]          w_corr_x;
    logic [1:0]                    w_mode;
    logic                          w_lf;
    logic                          w_rf;
    logic [lfps_pkg::DUTY_W-1:0]   w_lduty;
    logic [lfps_pkg::DUTY_W-1:0]   w_rduty;

    always_comb begin
        w_base   = $signed({3'b000, r_base, {lfps_pkg::FRAC_W{1'b0}}});
        w_corr_x = {{(XW - lfps_pkg::CORR_W){r_corr[lfps_pkg::CORR_W-1]}}, r_corr};
        if (r_hits[0] && !r_hits[NS-1]) begin
            w_mode  = lfps_pkg::MODE_TURN_LEFT;
            w_lf    = 1'b0;
            w_rf    = 1'b1;
            w_lduty = clamp_duty(w_base, r_min, r_max);
            w_rduty = w_lduty;
        end else if (r_hits[NS-1] && !r_hits[0]) begin
            w_mode  = lfps_pkg::MODE_TURN_RIGHT;
            w_lf    = 1'b1;
            w_rf    = 1'b0;
            w_lduty = clamp_duty(w_base, r_min, r_max);
            w_rduty = w_lduty;
        end else begin
            w_mode  = lfps_pkg::MODE_FOLLOW;
            w_lf    = 1'b1;
            w_rf    = 1'b1;
            w_lduty = clamp_duty(w_base + w_corr_x, r_min, r_max);
            w_rduty = clamp_duty(w_base - w_corr_x, r_min, r_max);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_acc  = r_ovld && m_axis_tready;
    assign w_out_free = !r_ovld || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_SCAN;
            S_SCAN: if (r_cnt == 3'(NS - 1)) n_state = S_PICK;
            S_PICK: n_state = (r_n != '0) ? S_DIV : S_PREP;
            S_DIV:  if (w_div_done) n_state = S_PREP;
            S_PREP: n_state = S_MAC;
            S_MAC:  if (r_cnt == 3'd3) n_state = S_CORR;
            S_CORR: n_state = S_DUTY;
            S_DUTY: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_n        <= '0;
            r_w        <= '0;
            r_last_err <= '0;
            r_esum     <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_n   <= '0;
                    r_w   <= '0;
                end
                S_SCAN: begin
                    r_cnt <= (r_cnt == 3'(NS - 1)) ? '0 : (r_cnt + 1'b1);
                    if (w_hit) begin
                        r_n <= r_n + 1'b1;
                        r_w <= r_w + lfps_pkg::sensor_weight(r_cnt);
                    end
                end
                S_PREP: begin
                    r_cnt      <= '0;
                    r_last_err <= r_err;
                    r_esum     <= w_esum_c[lfps_pkg::ESUM_W-1:0];
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
            // hold the result until taken; a new one lands only in the duty state
            if (r_state == S_DUTY && w_out_free) begin
                r_ovld <= 1'b1;
            end else if (w_out_acc) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < NS; i++) begin
                r_samp[i] <= s_axis_tdata[i*SW +: SW];
            end
        end else if (r_state == S_SCAN) begin
            for (int i = 0; i < NS - 1; i++) begin
                r_samp[i] <= r_samp[i+1];
            end
            r_hits <= {w_hit, r_hits[NS-1:1]};
        end
        if (r_state == S_PICK) begin
            r_neg <= w_wm1[lfps_pkg::WEIGHT_W-1];
            if (r_n == '0) begin
                // line lost: push hard toward the side it was last seen
                r_err <= (r_last_err > 0) ? lfps_pkg::ERR_W'(lfps_pkg::ERR_LOST)
                                          : -lfps_pkg::ERR_W'(lfps_pkg::ERR_LOST);
            end
        end
        if (r_state == S_DIV && w_div_done) begin
            r_err <= r_neg ? -$signed({1'b0, w_div_quot}) : $signed({1'b0, w_div_quot});
        end
        if (r_state == S_PREP) begin
            r_diff <= w_diff;
        end
        if (r_state == S_CORR) begin
            r_corr <= w_corr;
        end
        if (r_state == S_DUTY && w_out_free) begin
            r_mode  <= w_mode;
            r_lf    <= w_lf;
            r_rf    <= w_rf;
            r_lduty <= w_lduty;
            r_rduty <= w_rduty;
            r_oerr  <= r_err;
            r_ocorr <= r_corr;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {1'b0, r_ocorr, r_oerr, r_rduty, r_lduty, r_rf, r_lf, r_mode};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SCAN) && !s_axis_tready)
        else $error("accepted transaction did not start the scan");

    a_last_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_err <= 13'sd2048) && (r_last_err >= -13'sd2048))
        else $error("stored error out of range");

    a_result_from_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state == S_DUTY))
        else $error("result appeared outside the duty state");

    a_mac_idle_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_ctl.vld |-> (r_state == S_MAC) && (r_cnt != 3'd3))
        else $error("multiply issued outside its slots");

endmodule

// ===== tb/line_follow_pd_steering_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for line_follow_pd_steering: sends sensor sample
// transactions and configuration writes, predicts each steering result and
// compares it field by field. Depends on lfps_pkg and the design sources.
module line_follow_pd_steering_tb;
    import lfps_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 5;
    localparam int WATCHDOG_LIM  = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 110;
    localparam int MAX_REPORTS   = 10;
    localparam int POS_WEIGHT [SENSOR_COUNT] = '{-5, -3, 1, 3, 5};

    // Far-left reading in the lowest bits
    typedef logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] sample_set_t;

    // Packed from the lowest bit up: turn_mode first
    typedef struct packed {
        logic signed [CORR_W-1:0] correction;
        logic signed [ERR_W-1:0]  line_error;
        logic [DUTY_W-1:0]        right_duty;
        logic [DUTY_W-1:0]        left_duty;
        logic                     right_fwd;
        logic                     left_fwd;
        logic [1:0]               turn_mode;
    } steer_result_t;

    localparam int RESULT_W = $bits(steer_result_t);

    typedef struct packed {
        logic [PCT_W-1:0]  base_duty;
        logic [PCT_W-1:0]  min_duty;
        logic [PCT_W-1:0]  max_duty;
        logic [THR_W-1:0]  hit_thr;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [ILIM_W-1:0] int_limit;
    } steer_cfg_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    // sample_far_left, sample_near_left, sample_center, sample_near_right,
    // sample_far_right (12 bits each), zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // turn_mode, left_forward, right_forward, left_duty, right_duty,
    // line_error, steer_correction, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    steer_cfg_t    model_cfg;
    int            last_error_q8;
    int            error_sum_q8;
    steer_result_t expected_steer_q [$];
    int            mismatches    = 0;
    int            src_idle_pct  = 0;
    int            snk_stall_pct = 0;
    int            quiet_cycles  = 0;
    int            phase_no      = 0;

    line_follow_pd_steering u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic steer_cfg_t config_at_reset();
        steer_cfg_t c;
        c.base_duty = 7'd55;
        c.min_duty  = 7'd44;
        c.max_duty  = 7'd64;
        c.hit_thr   = 10'd950;
        c.gain_p    = 16'd230;
        c.gain_i    = 16'd0;
        c.gain_d    = 16'd1664;
        c.int_limit = 6'd30;
        return c;
    endfunction

    task automatic reset_model();
        model_cfg     = config_at_reset();
        last_error_q8 = 0;
        error_sum_q8  = 0;
    endtask

    task automatic model_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BASE_DUTY:      model_cfg.base_duty = data[PCT_W-1:0];
            CFG_MIN_DUTY:       model_cfg.min_duty  = data[PCT_W-1:0];
            CFG_MAX_DUTY:       model_cfg.max_duty  = data[PCT_W-1:0];
            CFG_HIT_THRESHOLD:  model_cfg.hit_thr   = data[THR_W-1:0];
            CFG_GAIN_P:         model_cfg.gain_p    = data[GAIN_W-1:0];
            CFG_GAIN_I:         model_cfg.gain_i    = data[GAIN_W-1:0];
            CFG_GAIN_D:         model_cfg.gain_d    = data[GAIN_W-1:0];
            CFG_INTEGRAL_LIMIT: model_cfg.int_limit = data[ILIM_W-1:0];
            default: ;
        endcase
    endtask

    // Raise to the floor first, then cap: an inverted pair leaves the cap in force
    function automatic int duty_clamp(input int x);
        int lo;
        int hi;
        lo = int'(model_cfg.min_duty) * 256;
        hi = int'(model_cfg.max_duty) * 256;
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return x;
    endfunction

    // Advances the error history and integral, as the block does per transaction
    function automatic steer_result_t steer_predict(input sample_set_t smp);
        logic [SENSOR_COUNT-1:0] hit;
        int            hits;
        int            wsum;
        int            scaled;
        int            err;
        int            diff;
        int            lim;
        int            base;
        int            corr;
        int            duty_l;
        int            duty_r;
        longint        acc;
        longint        quo;
        steer_result_t r;
        hits = 0;
        wsum = 0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            scaled = (int'(smp[k]) * SCALE_RANGE) / FULL_SCALE;
            hit[k] = (SCALE_RANGE - scaled) > int'(model_cfg.hit_thr);
            if (hit[k]) begin
                hits++;
                wsum += POS_WEIGHT[k];
            end
        end
        if (hits > 0) err = ((wsum - 1) * 256) / hits;
        else err = (last_error_q8 > 0) ? ERR_LOST : -ERR_LOST;

        diff = err - last_error_q8;
        lim  = int'(model_cfg.int_limit) * 256;
        error_sum_q8 += err;
        if (error_sum_q8 > lim) error_sum_q8 = lim;
        if (error_sum_q8 < -lim) error_sum_q8 = -lim;

        acc = longint'(model_cfg.gain_p) * err + longint'(model_cfg.gain_i) * error_sum_q8
            + longint'(model_cfg.gain_d) * diff;
        quo = acc / 256;
        if (quo > 32767) quo = 32767;
        if (quo < -32768) quo = -32768;
        corr = int'(quo);
        last_error_q8 = err;

        base = int'(model_cfg.base_duty) * 256;
        if (hit[0] && !hit[SENSOR_COUNT-1]) begin
            r.turn_mode = MODE_TURN_LEFT;
            r.left_fwd  = 1'b0;
            r.right_fwd = 1'b1;
            duty_l      = duty_clamp(base);
            duty_r      = duty_l;
        end else if (hit[SENSOR_COUNT-1] && !hit[0]) begin
            r.turn_mode = MODE_TURN_RIGHT;
            r.left_fwd  = 1'b1;
            r.right_fwd = 1'b0;
            duty_l      = duty_clamp(base);
            duty_r      = duty_l;
        end else begin
            r.turn_mode = MODE_FOLLOW;
            r.left_fwd  = 1'b1;
            r.right_fwd = 1'b1;
            duty_l      = duty_clamp(base + corr);
            duty_r      = duty_clamp(base - corr);
        end
        r.left_duty  = duty_l[DUTY_W-1:0];
        r.right_duty = duty_r[DUTY_W-1:0];
        r.line_error = err[ERR_W-1:0];
        r.correction = corr[CORR_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // Largest raw reading that still counts as line seen; -1 when none can
    function automatic int hit_ceiling();
        int span;
        if (int'(model_cfg.hit_thr) >= SCALE_RANGE) return -1;
        span = SCALE_RANGE - int'(model_cfg.hit_thr);
        return (span * FULL_SCALE + SCALE_RANGE - 1) / SCALE_RANGE - 1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] reading_for(input bit on_line);
        int top;
        top = hit_ceiling();
        if (top < 0) return $urandom_range(FULL_SCALE);
        // land right on the decision boundary now and then
        if ($urandom_range(7) == 0) return on_line ? top : top + 1;
        return on_line ? $urandom_range(top, 0) : $urandom_range(FULL_SCALE, top + 1);
    endfunction

    function automatic sample_set_t readings_from_mask(input logic [SENSOR_COUNT-1:0] mask,
                                                       input logic [SAMPLE_W-1:0] on_val,
                                                       input logic [SAMPLE_W-1:0] off_val);
        sample_set_t smp;
        for (int k = 0; k < SENSOR_COUNT; k++) smp[k] = mask[k] ? on_val : off_val;
        return smp;
    endfunction

    function automatic sample_set_t random_samples();
        sample_set_t             smp;
        logic [SENSOR_COUNT-1:0] mask;
        int                      pick;
        int                      run;
        int                      lead;
        pick = $urandom_range(99);
        if (pick < 15) begin
            for (int k = 0; k < SENSOR_COUNT; k++) smp[k] = $urandom_range(FULL_SCALE);
            return smp;
        end
        if (pick < 25) begin
            mask = '0;
        end else if (pick < 60) begin
            mask = $urandom_range(2 ** SENSOR_COUNT - 1);
        end else begin
            // line under one to three adjacent sensors
            run  = $urandom_range(3, 1);
            lead = $urandom_range(SENSOR_COUNT - run);
            mask = '0;
            for (int k = lead; k < lead + run; k++) mask[k] = 1'b1;
        end
        for (int k = 0; k < SENSOR_COUNT; k++) smp[k] = reading_for(mask[k]);
        return smp;
    endfunction

    function automatic steer_cfg_t random_config();
        steer_cfg_t c;
        c.base_duty = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(100);
        c.min_duty  = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(60);
        c.max_duty  = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(100, 40);
        c.hit_thr   = $urandom_range(1023);
        c.gain_p    = $urandom_range(1) ? $urandom_range(2047) : $urandom;
        c.gain_i    = $urandom_range(1) ? $urandom_range(255) : $urandom;
        c.gain_d    = $urandom_range(1) ? $urandom_range(4095) : $urandom;
        c.int_limit = $urandom_range(63);
        return c;
    endfunction

    // Unused upper data bits carry noise when asked; the register keeps its width only
    function automatic logic [CFG_DATA_W-1:0] with_noise(input int value, input int width,
                                                         input bit dirty);
        logic [CFG_DATA_W-1:0] d;
        d = dirty ? CFG_DATA_W'($urandom) : '0;
        d = ((d >> width) << width) | CFG_DATA_W'(value);
        return d;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        model_config(idx, data);
    endtask

    task automatic apply_config(input steer_cfg_t c, input bit dirty);
        write_reg(CFG_BASE_DUTY,      with_noise(c.base_duty, PCT_W, dirty));
        write_reg(CFG_MIN_DUTY,       with_noise(c.min_duty, PCT_W, dirty));
        write_reg(CFG_MAX_DUTY,       with_noise(c.max_duty, PCT_W, dirty));
        write_reg(CFG_HIT_THRESHOLD,  with_noise(c.hit_thr, THR_W, dirty));
        write_reg(CFG_GAIN_P,         with_noise(c.gain_p, GAIN_W, dirty));
        write_reg(CFG_GAIN_I,         with_noise(c.gain_i, GAIN_W, dirty));
        write_reg(CFG_GAIN_D,         with_noise(c.gain_d, GAIN_W, dirty));
        write_reg(CFG_INTEGRAL_LIMIT, with_noise(c.int_limit, ILIM_W, dirty));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input sample_set_t smp);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= IN_TDATA_W'(smp);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_steer_q.push_back(steer_predict(smp));
    endtask

    // Drop valid, drain every outstanding result, then let the pipeline go quiet
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_steer_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic next_idling();
        case (phase_no % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 51; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 51; end
            default: begin src_idle_pct = 19; snk_stall_pct = 19; end
        endcase
        phase_no++;
    endtask

    task automatic random_burst(input int count);
        next_idling();
        repeat (count) send_item(random_samples());
    endtask

    task automatic run_phase(input steer_cfg_t c, input bit dirty, input int count);
        settle();
        apply_config(c, dirty);
        random_burst(count);
    endtask

    // ---------------------------------------------------------------- tests

    // Mask bit 0 is far left. Covers lost line on either side of the history,
    // both turns, both edges together, and divisions that truncate.
    task automatic test_directed_patterns();
        logic [SENSOR_COUNT-1:0] patterns [20] = '{
            5'b00000, 5'b00100, 5'b01000, 5'b00000, 5'b00010, 5'b00000,
            5'b00001, 5'b10000, 5'b10001, 5'b11111, 5'b01110, 5'b00110,
            5'b01100, 5'b00011, 5'b11000, 5'b01010, 5'b11110, 5'b01111,
            5'b00111, 5'b11100};
        foreach (patterns[k])
            send_item(readings_from_mask(patterns[k], '0, FULL_SCALE[SAMPLE_W-1:0]));
    endtask

    task automatic test_hit_boundaries();
        logic [SAMPLE_W-1:0] top;
        top = hit_ceiling();
        send_item(readings_from_mask(5'b11111, top, top + 1'b1));
        send_item(readings_from_mask(5'b00000, top, top + 1'b1));
        send_item(readings_from_mask(5'b01101, top, top + 1'b1));
    endtask

    task automatic test_default_gains();
        random_burst(PHASE_ITEMS);
    endtask

    // Full-scale gains and duty range: the correction saturates both ways
    task automatic test_extreme_gains();
        steer_cfg_t c;
        c = '{base_duty: 7'd100, min_duty: 7'd0, max_duty: 7'd100, hit_thr: 10'd0,
              gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF, int_limit: 6'd63};
        run_phase(c, 1'b0, PHASE_ITEMS);
        c.hit_thr   = 10'd990;
        c.base_duty = 7'd127;
        c.max_duty  = 7'd127;
        run_phase(c, 1'b1, PHASE_ITEMS);
    endtask

    task automatic test_zero_config();
        steer_cfg_t c;
        c = '0;
        run_phase(c, 1'b0, PHASE_ITEMS);
    endtask

    // Threshold at or above full scale: nothing is ever seen
    task automatic test_blind_threshold();
        steer_cfg_t c;
        c         = random_config();
        c.hit_thr = 10'd1000;
        run_phase(c, 1'b0, 60);
        c.hit_thr = 10'd1023;
        run_phase(c, 1'b1, 60);
    endtask

    task automatic test_inverted_clamp();
        steer_cfg_t c;
        c           = random_config();
        c.base_duty = 7'd50;
        c.min_duty  = 7'd90;
        c.max_duty  = 7'd20;
        c.hit_thr   = 10'd900;
        run_phase(c, 1'b0, PHASE_ITEMS);
    endtask

    task automatic test_random_configs();
        repeat (7) run_phase(random_config(), $urandom_range(1), PHASE_ITEMS);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic flag_field(input string field, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %0s mismatch: expected %0d, got %0d", $realtime, field,
                         want, got);
        end
    endtask

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge i_clk) begin
        steer_result_t got;
        steer_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = steer_result_t'(m_axis_tdata[RESULT_W-1:0]);
            if (expected_steer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result transaction with none expected: %h", $realtime,
                             m_axis_tdata);
            end else begin
                want = expected_steer_q.pop_front();
                flag_field("turn_mode", want.turn_mode, got.turn_mode);
                flag_field("left_forward", want.left_fwd, got.left_fwd);
                flag_field("right_forward", want.right_fwd, got.right_fwd);
                flag_field("left_duty", want.left_duty, got.left_duty);
                flag_field("right_duty", want.right_duty, got.right_duty);
                flag_field("line_error", want.line_error, got.line_error);
                flag_field("steer_correction", want.correction, got.correction);
                flag_field("tdata pad", 0, m_axis_tdata[OUT_TDATA_W-1:RESULT_W]);
            end
        end
    end

    // Hold the run to a bound: too long without any transaction means a hang
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIM) begin
            $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIM);
            $display("** line_follow_pd_steering: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_patterns();
        test_hit_boundaries();
        test_default_gains();
        test_extreme_gains();
        test_zero_config();
        test_blind_threshold();
        test_inverted_clamp();
        test_random_configs();
        settle();

        if (mismatches == 0) begin
            $display("** line_follow_pd_steering: PASSED **");
        end else begin
            $display("** line_follow_pd_steering: FAILED **");
        end
        $finish;
    end

endmodule

// ===== line_follow_pd_steering.f =====
design/lfps_pkg.sv
design/lfps_div.sv
design/lfps_mac.sv
design/line_follow_pd_steering.sv
tb/line_follow_pd_steering_tb.sv
